FILE: hw/rtl/mlafs_pkg.sv
// Shared constants, codes and types of the multi-link converter frame sequencer.
package mlafs_pkg;

  localparam int LINKS          = 3;
  localparam int SLOTS_PER_LINK = 8;
  localparam int CHANNELS       = 24;
  localparam int STORE_DEPTH    = LINKS * SLOTS_PER_LINK;

  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int LINK_W    = 2;
  localparam int POS_W     = 3;
  localparam int CH_W      = 5;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int FAIL_W    = 16;
  localparam int OVR_W     = 32;
  localparam int KIND_W    = 3;

  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_SAMPLE   = 2'd1;
  localparam logic [1:0] CMD_COMPLETE = 2'd2;
  localparam logic [1:0] CMD_ERROR    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_STARTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OVERRUN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ABORTED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOTHING  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LINK0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LINK1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LINK2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd3;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

FILE: hw/rtl/mlafs_sample_store.sv
// Sample store: single-port-write, registered-read memory with per-entry valid bits.
module mlafs_sample_store
  import mlafs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  store_wr_t           wr,
  input  store_rd_t           rd,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0]    mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [SAMPLE_W-1:0]    rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld_r <= vld_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hw/rtl/multi_link_adc_frame_sequencer.sv
// Frame sequencer for three serial converter links: control, counters and result emission.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    cmd, link, position, sample, start_refused_mask
//  out_     output     out_valid/out_ready  kind, channel, sample_res, link_mask, done_mask,
//                                           abort_run, overrun_count, last
//  cfg_     input      cfg_valid/cfg_ready  index, data
//
// An item is accepted, then executed; an item that emits a result waits for a free result slot.
// A completion that closes the frame scans all store entries link-major, with a store read
// for each emitted channel that waits for a free result slot, and ends with the done marker.
// Reset is synchronous; the store needs no clearing pass, unwritten entries read as zero.
// A stalled output holds the sequencer in its emitting state; the next item is accepted
// while the last result of the previous one still waits.
module multi_link_adc_frame_sequencer
  import mlafs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [LINK_W-1:0]    in_link,
  input  logic [POS_W-1:0]     in_position,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  logic [LINKS-1:0]     in_start_refused_mask,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [CH_W-1:0]      out_channel,
  output logic [SAMPLE_W-1:0]  out_sample_res,
  output logic [LINKS-1:0]     out_link_mask,
  output logic [LINKS-1:0]     out_done_mask,
  output logic [FAIL_W-1:0]    out_abort_run,
  output logic [OVR_W-1:0]     out_overrun_count,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_READ, ST_DONE} state_t;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]   count_r [LINKS];
  logic [COUNT_W-1:0]   count_nxt [LINKS];
  logic [CHANNELS-1:0]  mask_r, mask_nxt;
  logic [COUNT_W-1:0]   snap_count_r [LINKS];
  logic [COUNT_W-1:0]   snap_count_nxt [LINKS];
  logic [CHANNELS-1:0]  snap_mask_r, snap_mask_nxt;

  logic                 busy_r, busy_nxt;
  logic [LINKS-1:0]     pending_r, pending_nxt;
  logic [LINKS-1:0]     done_r, done_nxt;
  logic [FAIL_W-1:0]    fail_r, fail_nxt;
  logic [OVR_W-1:0]     ovr_r, ovr_nxt;

  logic [1:0]           it_cmd_r, it_cmd_nxt;
  logic [LINK_W-1:0]    it_link_r, it_link_nxt;
  logic [POS_W-1:0]     it_pos_r, it_pos_nxt;
  logic [SAMPLE_W-1:0]  it_sample_r, it_sample_nxt;
  logic [LINKS-1:0]     it_refused_r, it_refused_nxt;

  logic [LINK_W-1:0]    scan_l_r, scan_l_nxt;
  logic [POS_W-1:0]     scan_p_r, scan_p_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [CH_W-1:0]      out_channel_r, out_channel_nxt;
  logic [SAMPLE_W-1:0]  out_sample_r, out_sample_nxt;
  logic [LINKS-1:0]     out_lm_r, out_lm_nxt;
  logic [LINKS-1:0]     out_dm_r, out_dm_nxt;
  logic [FAIL_W-1:0]    out_fail_r, out_fail_nxt;
  logic [OVR_W-1:0]     out_ovr_r, out_ovr_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 slot_free;
  logic [LINKS-1:0]     start_pend;
  logic                 start_abort;
  logic [CH_W-1:0]      scan_ch;
  logic                 scan_elig;
  logic                 scan_end;
  logic [LINKS-1:0]     it_bit;
  logic                 it_link_ok;

  store_wr_t            st_wr;
  store_rd_t            st_rd;
  logic [SAMPLE_W-1:0]  st_rd_data;

  mlafs_sample_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (st_rd_data)
  );

  assign slot_free  = !out_valid_r || out_ready;
  assign it_link_ok = (32'(it_link_r) < LINKS);
  assign it_bit     = it_link_ok ? LINKS'(1) << it_link_r : '0;

  always_comb begin
    start_pend  = '0;
    start_abort = 1'b0;
    for (int l = 0; l < LINKS; l++) begin
      if (!start_abort && count_r[l] != '0) begin
        if (it_refused_r[l]) begin
          start_abort = 1'b1;
        end else begin
          start_pend[l] = 1'b1;
        end
      end
    end
  end

  assign scan_ch   = CH_W'(scan_p_r) * CH_W'(LINKS) + CH_W'(scan_l_r);
  assign scan_elig = (COUNT_W'(scan_p_r) < snap_count_r[scan_l_r])
                     && (32'(scan_ch) < CHANNELS) && snap_mask_r[scan_ch];
  assign scan_end  = (scan_l_r == LINK_W'(LINKS - 1)) && (scan_p_r == POS_W'(SLOTS_PER_LINK - 1));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    mask_nxt        = mask_r;
    snap_count_nxt  = snap_count_r;
    snap_mask_nxt   = snap_mask_r;
    busy_nxt        = busy_r;
    pending_nxt     = pending_r;
    done_nxt        = done_r;
    fail_nxt        = fail_r;
    ovr_nxt         = ovr_r;
    it_cmd_nxt      = it_cmd_r;
    it_link_nxt     = it_link_r;
    it_pos_nxt      = it_pos_r;
    it_sample_nxt   = it_sample_r;
    it_refused_nxt  = it_refused_r;
    scan_l_nxt      = scan_l_r;
    scan_p_nxt      = scan_p_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_channel_nxt = out_channel_r;
    out_sample_nxt  = out_sample_r;
    out_lm_nxt      = out_lm_r;
    out_dm_nxt      = out_dm_r;
    out_fail_nxt    = out_fail_r;
    out_ovr_nxt     = out_ovr_r;
    out_last_nxt    = out_last_r;
    st_wr           = '0;
    st_rd           = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT_LINK0: count_nxt[0] = cfg_data[COUNT_W-1:0];
        CFG_COUNT_LINK1: count_nxt[1] = cfg_data[COUNT_W-1:0];
        CFG_COUNT_LINK2: count_nxt[2] = cfg_data[COUNT_W-1:0];
        CFG_ENABLE_MASK: mask_nxt     = cfg_data[CHANNELS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          it_cmd_nxt     = in_cmd;
          it_link_nxt    = in_link;
          it_pos_nxt     = in_position;
          it_sample_nxt  = in_sample;
          it_refused_nxt = in_start_refused_mask;
          state_nxt      = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (it_cmd_r)
          CMD_TICK: begin
            if (slot_free) begin
              snap_count_nxt  = count_r;
              snap_mask_nxt   = mask_r;
              out_valid_nxt   = 1'b1;
              out_channel_nxt = '0;
              out_sample_nxt  = '0;
              out_lm_nxt      = '0;
              out_dm_nxt      = '0;
              out_last_nxt    = 1'b1;
              out_fail_nxt    = fail_r;
              out_ovr_nxt     = ovr_r;
              if (busy_r) begin
                ovr_nxt      = ovr_r + 1'b1;
                out_ovr_nxt  = ovr_r + 1'b1;
                out_kind_nxt = KIND_OVERRUN;
              end else if (start_abort) begin
                busy_nxt     = 1'b0;
                pending_nxt  = '0;
                done_nxt     = '0;
                fail_nxt     = fail_r + 1'b1;
                out_fail_nxt = fail_r + 1'b1;
                out_kind_nxt = KIND_ABORTED;
                out_lm_nxt   = start_pend;
              end else if (start_pend == '0) begin
                pending_nxt  = '0;
                done_nxt     = '0;
                out_kind_nxt = KIND_NOTHING;
              end else begin
                busy_nxt     = 1'b1;
                pending_nxt  = start_pend;
                done_nxt     = '0;
                out_kind_nxt = KIND_STARTED;
                out_lm_nxt   = start_pend;
              end
              state_nxt = ST_IDLE;
            end
          end

          CMD_SAMPLE: begin
            st_wr.en   = it_link_ok && (32'(it_pos_r) < SLOTS_PER_LINK);
            st_wr.addr = ADDR_W'(it_link_r) * ADDR_W'(SLOTS_PER_LINK) + ADDR_W'(it_pos_r);
            st_wr.data = it_sample_r;
            state_nxt  = ST_IDLE;
          end

          CMD_COMPLETE: begin
            state_nxt = ST_IDLE;
            if (busy_r && (pending_r & it_bit) != '0) begin
              done_nxt = done_r | it_bit;
              if ((done_r | it_bit) == pending_r) begin
                scan_l_nxt = '0;
                scan_p_nxt = '0;
                state_nxt  = ST_SCAN;
              end
            end
          end

          default: begin
            if (!(it_link_ok && busy_r)) begin
              state_nxt = ST_IDLE;
            end else if (slot_free) begin
              busy_nxt        = 1'b0;
              pending_nxt     = '0;
              done_nxt        = '0;
              fail_nxt        = fail_r + 1'b1;
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = KIND_ABORTED;
              out_channel_nxt = '0;
              out_sample_nxt  = '0;
              out_lm_nxt      = pending_r;
              out_dm_nxt      = done_r;
              out_fail_nxt    = fail_r + 1'b1;
              out_ovr_nxt     = ovr_r;
              out_last_nxt    = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        if (scan_elig) begin
          st_rd.en   = 1'b1;
          st_rd.addr = ADDR_W'(scan_l_r) * ADDR_W'(SLOTS_PER_LINK) + ADDR_W'(scan_p_r);
          state_nxt  = ST_READ;
        end else if (scan_end) begin
          state_nxt = ST_DONE;
        end else if (scan_p_r == POS_W'(SLOTS_PER_LINK - 1)) begin
          scan_p_nxt = '0;
          scan_l_nxt = scan_l_r + 1'b1;
        end else begin
          scan_p_nxt = scan_p_r + 1'b1;
        end
      end

      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_SAMPLE;
          out_channel_nxt = scan_ch;
          out_sample_nxt  = st_rd_data;
          out_lm_nxt      = '0;
          out_dm_nxt      = '0;
          out_fail_nxt    = fail_r;
          out_ovr_nxt     = ovr_r;
          out_last_nxt    = 1'b0;
          if (scan_end) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
            if (scan_p_r == POS_W'(SLOTS_PER_LINK - 1)) begin
              scan_p_nxt = '0;
              scan_l_nxt = scan_l_r + 1'b1;
            end else begin
              scan_p_nxt = scan_p_r + 1'b1;
            end
          end
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          busy_nxt        = 1'b0;
          pending_nxt     = '0;
          done_nxt        = '0;
          fail_nxt        = '0;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_DONE;
          out_channel_nxt = '0;
          out_sample_nxt  = '0;
          out_lm_nxt      = '0;
          out_dm_nxt      = '0;
          out_fail_nxt    = '0;
          out_ovr_nxt     = ovr_r;
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '{default: '0};
      mask_r       <= '1;
      snap_count_r <= '{default: '0};
      snap_mask_r  <= '0;
      busy_r       <= 1'b0;
      pending_r    <= '0;
      done_r       <= '0;
      fail_r       <= '0;
      ovr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      mask_r       <= mask_nxt;
      snap_count_r <= snap_count_nxt;
      snap_mask_r  <= snap_mask_nxt;
      busy_r       <= busy_nxt;
      pending_r    <= pending_nxt;
      done_r       <= done_nxt;
      fail_r       <= fail_nxt;
      ovr_r        <= ovr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    it_cmd_r      <= it_cmd_nxt;
    it_link_r     <= it_link_nxt;
    it_pos_r      <= it_pos_nxt;
    it_sample_r   <= it_sample_nxt;
    it_refused_r  <= it_refused_nxt;
    scan_l_r      <= scan_l_nxt;
    scan_p_r      <= scan_p_nxt;
    out_kind_r    <= out_kind_nxt;
    out_channel_r <= out_channel_nxt;
    out_sample_r  <= out_sample_nxt;
    out_lm_r      <= out_lm_nxt;
    out_dm_r      <= out_dm_nxt;
    out_fail_r    <= out_fail_nxt;
    out_ovr_r     <= out_ovr_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_channel       = out_channel_r;
  assign out_sample_res    = out_sample_r;
  assign out_link_mask     = out_lm_r;
  assign out_done_mask     = out_dm_r;
  assign out_abort_run     = out_fail_r;
  assign out_overrun_count = out_ovr_r;
  assign out_last          = out_last_r;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the multi-link converter frame sequencer.
module tb
  import mlafs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 345;
  localparam int PHASE_ITEMS    = 58;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [LINK_W-1:0]   link;
    logic [POS_W-1:0]    position;
    logic [SAMPLE_W-1:0] sample;
    logic [LINKS-1:0]    refused;
  } seq_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample_res;
    logic [LINKS-1:0]    link_mask;
    logic [LINKS-1:0]    done_mask;
    logic [FAIL_W-1:0]   abort_run;
    logic [OVR_W-1:0]    overrun_count;
    logic                last;
  } frame_res_t;

  typedef struct packed {
    logic                 is_cfg;
    logic                 typed;
    seq_item_t            it;
    frame_res_t           res;
    logic [COUNT_W-1:0]   c0;
    logic [COUNT_W-1:0]   c1;
    logic [COUNT_W-1:0]   c2;
    logic [CFG_DAT_W-1:0] mask;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = CMD_TICK;
  logic [LINK_W-1:0]    in_link = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic [LINKS-1:0]     in_start_refused_mask = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_kind;
  logic [CH_W-1:0]      out_channel;
  logic [SAMPLE_W-1:0]  out_sample_res;
  logic [LINKS-1:0]     out_link_mask;
  logic [LINKS-1:0]     out_done_mask;
  logic [FAIL_W-1:0]    out_abort_run;
  logic [OVR_W-1:0]     out_overrun_count;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COUNT_LINK0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  multi_link_adc_frame_sequencer uut (.*);

  always #HALF_PERIOD clk = ~clk;

  // Predictor state
  logic [COUNT_W-1:0]   p_cnt [LINKS];
  logic [CFG_DAT_W-1:0] p_mask;
  logic [COUNT_W-1:0]   p_snap_cnt [LINKS];
  logic [CFG_DAT_W-1:0] p_snap_mask;
  logic                 p_busy;
  logic [LINKS-1:0]     p_pend;
  logic [LINKS-1:0]     p_done;
  logic [FAIL_W-1:0]    p_fail;
  logic [OVR_W-1:0]     p_ovr;
  logic [SAMPLE_W-1:0]  p_store [STORE_DEPTH];

  frame_res_t frame_events_q [$];
  frame_res_t step_events [$];
  plan_row_t  plan [$];
  int         err_count = 0;
  int         quiet_cycles = 0;
  int         burst_left = 0;
  int         rx_left = 0;
  int         rx_period = 1;
  int         rx_duty = 1;
  int         rx_phase = 0;

  function automatic frame_res_t mk_res(logic [KIND_W-1:0] k, logic [CH_W-1:0] ch,
                                        logic [SAMPLE_W-1:0] s, logic [LINKS-1:0] lm,
                                        logic [LINKS-1:0] dm);
    frame_res_t r;
    r = '{k, ch, s, lm, dm, p_fail, p_ovr, 1'b0};
    return r;
  endfunction

  function automatic void abort_frame();
    logic [LINKS-1:0] lm;
    logic [LINKS-1:0] dm;
    lm = p_pend;
    dm = p_done;
    p_busy = 1'b0;
    p_pend = '0;
    p_done = '0;
    p_fail = p_fail + 1'b1;
    step_events.push_back(mk_res(KIND_ABORTED, '0, '0, lm, dm));
  endfunction

  function automatic void close_frame();
    int ch;
    for (int l = 0; l < LINKS; l++) begin
      for (int p = 0; p < SLOTS_PER_LINK; p++) begin
        ch = p * LINKS + l;
        if (p < p_snap_cnt[l] && ch < CHANNELS && p_snap_mask[ch])
          step_events.push_back(mk_res(KIND_SAMPLE, CH_W'(ch),
                                       p_store[l * SLOTS_PER_LINK + p], '0, '0));
      end
    end
    p_busy = 1'b0;
    p_pend = '0;
    p_done = '0;
    p_fail = '0;
    step_events.push_back(mk_res(KIND_DONE, '0, '0, '0, '0));
  endfunction

  function automatic void predict_frame_events(seq_item_t it);
    logic       stop;
    frame_res_t r;
    step_events.delete();
    case (it.cmd)
      CMD_TICK: begin
        p_snap_cnt  = p_cnt;
        p_snap_mask = p_mask;
        if (p_busy) begin
          p_ovr = p_ovr + 1'b1;
          step_events.push_back(mk_res(KIND_OVERRUN, '0, '0, '0, '0));
        end else begin
          p_busy = 1'b1;
          p_pend = '0;
          p_done = '0;
          stop   = 1'b0;
          for (int l = 0; l < LINKS; l++) begin
            if (!stop && p_cnt[l] != 0) begin
              if (it.refused[l]) begin
                abort_frame();
                stop = 1'b1;
              end else begin
                p_pend[l] = 1'b1;
              end
            end
          end
          if (!stop) begin
            if (p_pend == '0) begin
              p_busy = 1'b0;
              step_events.push_back(mk_res(KIND_NOTHING, '0, '0, '0, '0));
            end else begin
              step_events.push_back(mk_res(KIND_STARTED, '0, '0, p_pend, '0));
            end
          end
        end
      end
      CMD_SAMPLE: begin
        if (it.link < LINKS && it.position < SLOTS_PER_LINK)
          p_store[it.link * SLOTS_PER_LINK + it.position] = it.sample;
      end
      CMD_COMPLETE: begin
        if (it.link < LINKS && p_busy && p_pend[it.link]) begin
          p_done[it.link] = 1'b1;
          if (p_done == p_pend) close_frame();
        end
      end
      default: begin
        if (it.link < LINKS && p_busy) abort_frame();
      end
    endcase
    if (step_events.size() != 0) begin
      r = step_events.pop_back();
      r.last = 1'b1;
      step_events.push_back(r);
    end
  endfunction

  function automatic void add_item(logic [1:0] cmd, logic [LINK_W-1:0] link,
                                   logic [POS_W-1:0] pos, logic [SAMPLE_W-1:0] smp,
                                   logic [LINKS-1:0] refused);
    plan_row_t row;
    row = '0;
    row.it = '{cmd, link, pos, smp, refused};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(logic [1:0] cmd, logic [LINK_W-1:0] link,
                                    logic [LINKS-1:0] refused, logic [KIND_W-1:0] kind,
                                    logic [LINKS-1:0] lm, logic [LINKS-1:0] dm,
                                    logic [FAIL_W-1:0] fail, logic [OVR_W-1:0] ovr);
    plan_row_t row;
    row = '0;
    row.typed = 1'b1;
    row.it = '{cmd, link, '0, '0, refused};
    row.res = '{kind, '0, '0, lm, dm, fail, ovr, 1'b1};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [COUNT_W-1:0] c0, logic [COUNT_W-1:0] c1,
                                  logic [COUNT_W-1:0] c2, logic [CFG_DAT_W-1:0] mask);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.c0 = c0;
    row.c1 = c1;
    row.c2 = c2;
    row.mask = mask;
    plan.push_back(row);
  endfunction

  function automatic void build_plan();
    // Reset settings: no converters on any link
    add_typed(CMD_TICK, 2'd0, 3'd0, KIND_NOTHING, 3'd0, 3'd0, 16'd0, 32'd0);
    add_item(CMD_COMPLETE, 2'd0, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_ERROR, 2'd2, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_SAMPLE, 2'd3, 3'd7, 16'hFFFF, 3'd7);
    add_typed(CMD_TICK, 2'd0, 3'd7, KIND_NOTHING, 3'd0, 3'd0, 16'd0, 32'd0);
    // Full chains, every channel enabled
    add_cfg(4'd8, 4'd8, 4'd8, 24'hFFFFFF);
    add_item(CMD_SAMPLE, 2'd0, 3'd0, 16'hFFFF, 3'd0);
    add_item(CMD_SAMPLE, 2'd1, 3'd7, 16'h5A5A, 3'd0);
    add_item(CMD_SAMPLE, 2'd2, 3'd3, 16'h8000, 3'd0);
    add_item(CMD_SAMPLE, 2'd2, 3'd7, 16'h0000, 3'd0);
    add_typed(CMD_TICK, 2'd0, 3'd0, KIND_STARTED, 3'd7, 3'd0, 16'd0, 32'd0);
    add_typed(CMD_TICK, 2'd0, 3'd5, KIND_OVERRUN, 3'd0, 3'd0, 16'd0, 32'd1);
    add_item(CMD_COMPLETE, 2'd3, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd0, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd0, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd1, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd2, 3'd0, 16'h0000, 3'd0);
    add_typed(CMD_TICK, 2'd0, 3'd2, KIND_ABORTED, 3'd1, 3'd0, 16'd1, 32'd1);
    add_typed(CMD_TICK, 2'd0, 3'd0, KIND_STARTED, 3'd7, 3'd0, 16'd1, 32'd1);
    add_item(CMD_COMPLETE, 2'd2, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_ERROR, 2'd3, 3'd0, 16'h0000, 3'd0);
    add_typed(CMD_ERROR, 2'd1, 3'd0, KIND_ABORTED, 3'd7, 3'd4, 16'd2, 32'd1);
    add_typed(CMD_TICK, 2'd0, 3'd1, KIND_ABORTED, 3'd0, 3'd0, 16'd3, 32'd1);
    // Uneven chains, an empty link, sparse enables
    add_cfg(4'd3, 4'd0, 4'd8, 24'h5C3A96);
    add_item(CMD_TICK, 2'd0, 3'd0, 16'h0000, 3'd2);
    add_item(CMD_COMPLETE, 2'd2, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd0, 3'd0, 16'h0000, 3'd0);
    // Every channel disabled
    add_cfg(4'd0, 4'd1, 4'd0, 24'h000000);
    add_item(CMD_TICK, 2'd0, 3'd0, 16'h0000, 3'd0);
    add_item(CMD_COMPLETE, 2'd1, 3'd0, 16'h0000, 3'd0);
  endfunction

  function automatic logic [LINK_W-1:0] sample_link();
    return ($urandom_range(0, 9) == 0) ? LINK_W'(3) : LINK_W'($urandom_range(0, LINKS - 1));
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? COUNT_W'(8) : '0;
    return COUNT_W'($urandom_range(0, 8));
  endfunction

  function automatic seq_item_t gen_item();
    seq_item_t        it;
    int               r;
    logic [LINKS-1:0] open_links;
    it.cmd      = 2'($urandom_range(0, 3));
    it.link     = LINK_W'($urandom_range(0, 3));
    it.position = POS_W'($urandom_range(0, 7));
    it.sample   = SAMPLE_W'($urandom_range(0, 65535));
    it.refused  = LINKS'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    open_links = p_pend & ~p_done;
    if (!p_busy) begin
      if (r < 40) begin
        it.cmd = CMD_TICK;
        if ($urandom_range(0, 3) != 0) it.refused = '0;
      end else if (r < 88) begin
        it.cmd  = CMD_SAMPLE;
        it.link = sample_link();
      end
    end else begin
      if (r < 50) begin
        it.cmd  = CMD_COMPLETE;
        it.link = LINK_W'($urandom_range(0, LINKS - 1));
        while (!open_links[it.link]) it.link = LINK_W'($urandom_range(0, LINKS - 1));
      end else if (r < 78) begin
        it.cmd  = CMD_SAMPLE;
        it.link = sample_link();
      end else if (r < 84) begin
        it.cmd = CMD_ERROR;
      end else if (r < 90) begin
        it.cmd = CMD_TICK;
      end
    end
    return it;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  task automatic idle_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_events_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 15) == 0) gap = 30;
      if (gap > 0) idle_sender(gap);
    end
    burst_left--;
  endtask

  // Hold valid high across back-to-back transactions, change payload only
  task automatic push_item(seq_item_t it, logic typed, frame_res_t typed_res);
    in_valid              <= 1'b1;
    in_cmd                <= it.cmd;
    in_link               <= it.link;
    in_position           <= it.position;
    in_sample             <= it.sample;
    in_start_refused_mask <= it.refused;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_events(it);
    if (typed) frame_events_q.push_back(typed_res);
    else foreach (step_events[i]) frame_events_q.push_back(step_events[i]);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COUNT_LINK0: p_cnt[0] = data[COUNT_W-1:0];
      CFG_COUNT_LINK1: p_cnt[1] = data[COUNT_W-1:0];
      CFG_COUNT_LINK2: p_cnt[2] = data[COUNT_W-1:0];
      default:         p_mask = data;
    endcase
    @(negedge clk);
  endtask

  task automatic write_config(logic [COUNT_W-1:0] c0, logic [COUNT_W-1:0] c1,
                              logic [COUNT_W-1:0] c2, logic [CFG_DAT_W-1:0] mask);
    write_reg(CFG_COUNT_LINK0, CFG_DAT_W'(c0));
    write_reg(CFG_COUNT_LINK1, CFG_DAT_W'(c1));
    write_reg(CFG_COUNT_LINK2, CFG_DAT_W'(c2));
    write_reg(CFG_ENABLE_MASK, mask);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_left   = $urandom_range(32, 160);
      rx_period = $urandom_range(1, 12);
      rx_duty   = $urandom_range(1, rx_period);
      rx_phase  = 0;
    end
    out_ready <= (rx_phase < rx_duty);
    rx_phase = (rx_phase + 1 == rx_period) ? 0 : rx_phase + 1;
    rx_left--;
  end

  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_events_q.size() == 0) begin
          $error("result with no expectation: kind %0d channel %0d", out_kind, out_channel);
          err_count++;
        end else begin
          want = frame_events_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("channel", 32'(want.channel), 32'(out_channel));
          check_field("sample_res", 32'(want.sample_res), 32'(out_sample_res));
          check_field("link_mask", 32'(want.link_mask), 32'(out_link_mask));
          check_field("done_mask", 32'(want.done_mask), 32'(out_done_mask));
          check_field("abort_run", 32'(want.abort_run), 32'(out_abort_run));
          check_field("overrun_count", want.overrun_count, out_overrun_count);
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_DAT_W-1:0] mask;
    int                   pick;
    for (int l = 0; l < LINKS; l++) begin
      p_cnt[l]      = '0;
      p_snap_cnt[l] = '0;
    end
    p_mask      = 24'hFFFFFF;
    p_snap_mask = '0;
    p_busy      = 1'b0;
    p_pend      = '0;
    p_done      = '0;
    p_fail      = '0;
    p_ovr       = '0;
    foreach (p_store[i]) p_store[i] = '0;
    build_plan();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_config(plan[i].c0, plan[i].c1, plan[i].c2, plan[i].mask);
      end else begin
        pace();
        push_item(plan[i].it, plan[i].typed, plan[i].res);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        drain();
        pick = $urandom_range(0, 3);
        case (pick)
          0:       mask = 24'hFFFFFF;
          1:       mask = '0;
          default: mask = CFG_DAT_W'($urandom);
        endcase
        write_config(rand_count(), rand_count(), rand_count(), mask);
      end
      pace();
      push_item(gen_item(), 1'b0, '0);
    end

    drain();
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mlafs_pkg.sv
hw/rtl/mlafs_sample_store.sv
hw/rtl/multi_link_adc_frame_sequencer.sv
sim/tb.sv
